// ===== design/chip8_instruction_execute_core_assert.svh =====
// Assertion macros shared by the CHIP-8 execute core.
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHIP8_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chip8 core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHIP8_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chip8 core assertion failed");

`endif

// ===== design/chip8_pkg.sv =====
// Shared types and constants of the CHIP-8 execute core.
package chip8_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int STACK_DEPTH   = 16;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int QDEPTH        = 2;

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int XW  = $clog2(SCREEN_WIDTH);
  localparam int YW  = $clog2(SCREEN_HEIGHT);
  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [11:0] FONT_RESET = 12'd80;

  typedef enum logic [1:0] {
    KIND_EXEC = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] instruction;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
    logic [11:0] load_address;
    logic [7:0]  load_data;
  } item_t;

  typedef struct packed {
    logic [QCW-1:0] count;
  } qstat_t;

  typedef struct packed {
    logic take;
    logic result_load;
  } estat_t;

endpackage

// ===== design/chip8_front.sv =====
// Front end: classifies incoming words and queues them for the execute unit.
module chip8_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [1:0]           opcode_i,
  input  logic [15:0]          instruction_i,
  input  logic [15:0]          key_mask_i,
  input  logic [7:0]           random_byte_i,
  input  logic [11:0]          load_address_i,
  input  logic [7:0]           load_data_i,
  output chip8_pkg::item_t     item_o,
  output logic                 valid_o,
  input  logic                 take_i,
  output chip8_pkg::qstat_t    stat_o
);

  chip8_pkg::item_t               slots_q [chip8_pkg::QDEPTH];
  logic [chip8_pkg::QPW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [chip8_pkg::QCW-1:0]      cnt_q;
  chip8_pkg::item_t               item_in;
  logic                           do_push, do_pop;

  always_comb begin
    item_in.instruction  = instruction_i;
    item_in.key_mask     = key_mask_i;
    item_in.random_byte  = random_byte_i;
    item_in.load_address = load_address_i;
    item_in.load_data    = load_data_i;
    case (opcode_i)
      2'd0:    item_in.kind = chip8_pkg::KIND_EXEC;
      2'd1:    item_in.kind = chip8_pkg::KIND_LOAD;
      2'd2:    item_in.kind = chip8_pkg::KIND_TICK;
      default: item_in.kind = chip8_pkg::KIND_NONE;
    endcase
  end

  assign full_o  = (cnt_q == chip8_pkg::QCW'(chip8_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;
  assign item_o  = slots_q[rd_ptr_q];
  assign stat_o.count = cnt_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == chip8_pkg::QPW'(chip8_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == chip8_pkg::QPW'(chip8_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/chip8_exec.sv =====
// Back end: sequencer that carries out one queued word against the machine state.
module chip8_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [11:0]        cfg_wdata_i,
  input  chip8_pkg::item_t   item_i,
  input  logic               valid_i,
  output logic               take_o,
  input  logic               pop,
  output logic               empty,
  output logic [11:0]        next_pc_o,
  output logic [15:0]        index_value_o,
  output logic [3:0]         dest_register_o,
  output logic [7:0]         dest_value_o,
  output logic [7:0]         flag_value_o,
  output logic               collision_o,
  output logic               screen_changed_o,
  output logic               waiting_for_key_o,
  output logic               sound_on_o,
  output logic [7:0]         delay_value_o,
  output chip8_pkg::estat_t  stat_o
);

  localparam int AW  = chip8_pkg::AW;
  localparam int SPW = chip8_pkg::SPW;
  localparam int XW  = chip8_pkg::XW;
  localparam int YW  = chip8_pkg::YW;
  localparam int SW  = chip8_pkg::SCREEN_WIDTH;
  localparam int SH  = chip8_pkg::SCREEN_HEIGHT;

  typedef enum logic [3:0] {
    S_IDLE, S_VX, S_VY, S_EXEC, S_DRAW_RD, S_DRAW_WR,
    S_BCD, S_STORE, S_LOAD_RD, S_LOAD_WR, S_DONE
  } state_e;

  state_e                        state_q;
  logic [15:0][7:0]              vregs_q;
  logic [15:0]                   i_q;
  logic [11:0]                   pc_q;
  logic [SPW-1:0]                sp_q;
  logic [11:0]                   stack_q [chip8_pkg::STACK_DEPTH];
  logic [SH-1:0][SW-1:0]         fb_q;
  logic [SH-1:0]                 row_lit_q;
  logic [7:0]                    delay_q, sound_q;
  logic [11:0]                   font_q;
  logic [7:0]                    mem [chip8_pkg::MEM_BYTES];
  logic [7:0]                    mem_rd_q;

  logic [15:0]                   ins_q, keys_q;
  logic [7:0]                    rnd_q;
  logic [3:0]                    vidx_q, cnt_q, dreg_q;
  logic [7:0]                    vx_q, vy_q, dval_q;
  logic                          coll_q, chg_q, wait_q;

  logic                          out_valid_q;
  logic [11:0]                   out_pc_q;
  logic [15:0]                   out_i_q;
  logic [3:0]                    out_dreg_q;
  logic [7:0]                    out_dval_q, out_flag_q, out_delay_q;
  logic                          out_coll_q, out_chg_q, out_wait_q, out_sound_q;

  logic [3:0]                    top_n, x_n, y_n, n_n;
  logic [7:0]                    kk;
  logic [11:0]                   nnn;
  logic                          take, out_free;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [7:0]                    mem_wdata;
  logic [1:0]                    hund;
  logic [7:0]                    rem;
  logic [14:0]                   tens_prod;
  logic [3:0]                    tens, ones;
  logic [7:0]                    py;
  logic [SW-1:0]                 mask, row_old;
  logic                          key_found;
  logic [3:0]                    key_num;
  logic [8:0]                    sum9;

  assign top_n = ins_q[15:12];
  assign x_n   = ins_q[11:8];
  assign y_n   = ins_q[7:4];
  assign n_n   = ins_q[3:0];
  assign kk    = ins_q[7:0];
  assign nnn   = ins_q[11:0];

  assign out_free = !out_valid_q || pop;
  assign take     = (state_q == S_IDLE) && valid_i;
  assign take_o   = take;
  assign stat_o.take        = take;
  assign stat_o.result_load = (state_q == S_DONE) && out_free;

  // Decimal digits of Vx; the tens digit uses a reciprocal multiply, exact below 100.
  always_comb begin
    if (vx_q >= 8'd200) begin
      hund = 2'd2;
    end else if (vx_q >= 8'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rem       = vx_q - 8'(hund) * 8'd100;
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    ones      = 4'(rem - 8'(tens) * 8'd10);
  end

  // Sprite row placement: bit SW-1 is the leftmost column.
  always_comb begin
    py      = 8'(vy_q[YW-1:0]) + 8'(cnt_q);
    mask    = {mem_rd_q, {(SW - 8){1'b0}}} >> vx_q[XW-1:0];
    row_old = fb_q[py[YW-1:0]];
  end

  always_comb begin
    key_found = 1'b0;
    key_num   = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) begin
        key_found = 1'b1;
        key_num   = 4'(k);
      end
    end
  end

  always_comb begin
    mem_raddr = AW'(i_q + 16'(cnt_q));
    mem_we    = 1'b0;
    mem_waddr = AW'(item_i.load_address);
    mem_wdata = item_i.load_data;
    case (state_q)
      S_IDLE: begin
        mem_we = take && (item_i.kind == chip8_pkg::KIND_LOAD);
      end
      S_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(i_q + 16'(cnt_q));
        case (cnt_q)
          4'd0:    mem_wdata = 8'(hund);
          4'd1:    mem_wdata = 8'(tens);
          default: mem_wdata = 8'(ones);
        endcase
      end
      S_STORE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(i_q + 16'(vidx_q));
        mem_wdata = vregs_q[vidx_q];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vregs_q     <= '0;
      i_q         <= '0;
      pc_q        <= chip8_pkg::PC_RESET;
      sp_q        <= '0;
      fb_q        <= '0;
      row_lit_q   <= '0;
      delay_q     <= '0;
      sound_q     <= '0;
      font_q      <= chip8_pkg::FONT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        font_q <= cfg_wdata_i;
      end
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (take) begin
            ins_q  <= item_i.instruction;
            keys_q <= item_i.key_mask;
            rnd_q  <= item_i.random_byte;
            vidx_q <= item_i.instruction[11:8];
            dreg_q <= 4'd0;
            dval_q <= 8'd0;
            coll_q <= 1'b0;
            chg_q  <= 1'b0;
            wait_q <= 1'b0;
            state_q <= S_DONE;
            case (item_i.kind)
              chip8_pkg::KIND_EXEC: begin
                pc_q    <= pc_q + 12'd2;
                state_q <= S_VX;
              end
              chip8_pkg::KIND_TICK: begin
                if (delay_q != 8'd0) delay_q <= delay_q - 8'd1;
                if (sound_q != 8'd0) sound_q <= sound_q - 8'd1;
              end
              default: ;
            endcase
          end
        end
        S_VX: begin
          vx_q    <= vregs_q[vidx_q];
          vidx_q  <= y_n;
          state_q <= S_VY;
        end
        S_VY: begin
          vy_q    <= vregs_q[vidx_q];
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_DONE;
          case (top_n)
            4'h0: begin
              if (ins_q == 16'h00E0) begin
                chg_q     <= |row_lit_q;
                fb_q      <= '0;
                row_lit_q <= '0;
              end else if (ins_q == 16'h00EE) begin
                sp_q <= sp_q - 1'b1;
                pc_q <= stack_q[sp_q - 1'b1];
              end
            end
            4'h1: pc_q <= nnn;
            4'h2: begin
              stack_q[sp_q] <= pc_q;
              sp_q <= sp_q + 1'b1;
              pc_q <= nnn;
            end
            4'h3: if (vx_q == kk) pc_q <= pc_q + 12'd2;
            4'h4: if (vx_q != kk) pc_q <= pc_q + 12'd2;
            4'h5: if (n_n == 4'd0 && vx_q == vy_q) pc_q <= pc_q + 12'd2;
            4'h6: begin
              vregs_q[x_n] <= kk;
              dreg_q <= x_n;
              dval_q <= kk;
            end
            4'h7: begin
              vregs_q[x_n] <= vx_q + kk;
              dreg_q <= x_n;
              dval_q <= vx_q + kk;
            end
            4'h8: begin
              // VF goes first, so a result aimed at VF overrides the flag.
              case (n_n)
                4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                  dreg_q <= x_n;
                  case (n_n)
                    4'h0: begin vregs_q[x_n] <= vy_q; dval_q <= vy_q; end
                    4'h1: begin vregs_q[x_n] <= vx_q | vy_q; dval_q <= vx_q | vy_q; end
                    4'h2: begin vregs_q[x_n] <= vx_q & vy_q; dval_q <= vx_q & vy_q; end
                    4'h3: begin vregs_q[x_n] <= vx_q ^ vy_q; dval_q <= vx_q ^ vy_q; end
                    4'h4: begin
                      vregs_q[15]  <= 8'(sum9[8]);
                      vregs_q[x_n] <= sum9[7:0];
                      dval_q       <= sum9[7:0];
                    end
                    4'h5: begin
                      vregs_q[15]  <= 8'(vx_q > vy_q);
                      vregs_q[x_n] <= vx_q - vy_q;
                      dval_q       <= vx_q - vy_q;
                    end
                    4'h6: begin
                      vregs_q[15]  <= 8'(vx_q[0]);
                      vregs_q[x_n] <= vx_q >> 1;
                      dval_q       <= vx_q >> 1;
                    end
                    4'h7: begin
                      vregs_q[15]  <= 8'(vy_q > vx_q);
                      vregs_q[x_n] <= vy_q - vx_q;
                      dval_q       <= vy_q - vx_q;
                    end
                    default: begin
                      vregs_q[15]  <= 8'(vx_q[7]);
                      vregs_q[x_n] <= vx_q << 1;
                      dval_q       <= vx_q << 1;
                    end
                  endcase
                end
                default: ;
              endcase
            end
            4'h9: if (n_n == 4'd0 && vx_q != vy_q) pc_q <= pc_q + 12'd2;
            4'hA: i_q <= 16'(nnn);
            4'hB: pc_q <= 12'(vregs_q[0]) + nnn;
            4'hC: begin
              vregs_q[x_n] <= rnd_q & kk;
              dreg_q <= x_n;
              dval_q <= rnd_q & kk;
            end
            4'hD: begin
              cnt_q   <= 4'd0;
              state_q <= S_DRAW_RD;
            end
            4'hE: begin
              if (kk == 8'h9E && vx_q < 8'd16 && keys_q[vx_q[3:0]]) begin
                pc_q <= pc_q + 12'd2;
              end else if (kk == 8'hA1 && !(vx_q < 8'd16 && keys_q[vx_q[3:0]])) begin
                pc_q <= pc_q + 12'd2;
              end
            end
            default: begin
              case (kk)
                8'h07: begin
                  vregs_q[x_n] <= delay_q;
                  dreg_q <= x_n;
                  dval_q <= delay_q;
                end
                8'h0A: begin
                  if (key_found) begin
                    vregs_q[x_n] <= 8'(key_num);
                    dreg_q <= x_n;
                    dval_q <= 8'(key_num);
                  end else begin
                    pc_q   <= pc_q - 12'd2;
                    wait_q <= 1'b1;
                  end
                end
                8'h15: delay_q <= vx_q;
                8'h18: sound_q <= vx_q;
                8'h1E: i_q <= i_q + 16'(vx_q);
                8'h29: i_q <= 16'(font_q) + 16'(vx_q) * 16'd5;
                8'h33: begin
                  cnt_q   <= 4'd0;
                  state_q <= S_BCD;
                end
                8'h55: begin
                  vidx_q  <= 4'd0;
                  state_q <= S_STORE;
                end
                8'h65: begin
                  cnt_q   <= 4'd0;
                  dreg_q  <= x_n;
                  state_q <= S_LOAD_RD;
                end
                default: ;
              endcase
            end
          endcase
        end
        S_DRAW_RD: begin
          // The memory read for row cnt_q is issued in this cycle.
          if (cnt_q == n_n || py >= 8'(SH)) begin
            vregs_q[15] <= 8'(coll_q);
            dreg_q      <= 4'hF;
            dval_q      <= 8'(coll_q);
            state_q     <= S_DONE;
          end else begin
            state_q <= S_DRAW_WR;
          end
        end
        S_DRAW_WR: begin
          fb_q[py[YW-1:0]]      <= row_old ^ mask;
          row_lit_q[py[YW-1:0]] <= |(row_old ^ mask);
          coll_q  <= coll_q | (|(row_old & mask));
          chg_q   <= chg_q | (|mask);
          cnt_q   <= cnt_q + 4'd1;
          state_q <= S_DRAW_RD;
        end
        S_BCD: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd2) state_q <= S_DONE;
        end
        S_STORE: begin
          vidx_q <= vidx_q + 4'd1;
          if (vidx_q == x_n) state_q <= S_DONE;
        end
        S_LOAD_RD: begin
          state_q <= S_LOAD_WR;
        end
        S_LOAD_WR: begin
          vregs_q[cnt_q] <= mem_rd_q;
          dval_q         <= mem_rd_q;
          cnt_q          <= cnt_q + 4'd1;
          state_q        <= (cnt_q == x_n) ? S_DONE : S_LOAD_RD;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pc_q    <= pc_q;
            out_i_q     <= i_q;
            out_dreg_q  <= dreg_q;
            out_dval_q  <= dval_q;
            out_flag_q  <= vregs_q[15];
            out_coll_q  <= coll_q;
            out_chg_q   <= chg_q;
            out_wait_q  <= wait_q;
            out_sound_q <= (sound_q != 8'd0);
            out_delay_q <= delay_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign sum9 = 9'(vx_q) + 9'(vy_q);

  assign empty             = !out_valid_q;
  assign next_pc_o         = out_pc_q;
  assign index_value_o     = out_i_q;
  assign dest_register_o   = out_dreg_q;
  assign dest_value_o      = out_dval_q;
  assign flag_value_o      = out_flag_q;
  assign collision_o       = out_coll_q;
  assign screen_changed_o  = out_chg_q;
  assign waiting_for_key_o = out_wait_q;
  assign sound_on_o        = out_sound_q;
  assign delay_value_o     = out_delay_q;

endmodule

// ===== design/chip8_instruction_execute_core.sv =====
// Top level of the CHIP-8 execute core: input queue, sequencer and result register.
//
//   channel   handshake          words
//   input     push / full        opcode, instruction, key mask, random byte, load
//   result    empty / pop        pc, I, destination, VF, draw and timer status
//   config    cfg_we_i           font_base, 12 bits
//
// A load, tick or idle word goes from idle straight to the result state; an instruction
// reads Vx, then Vy, then executes, and Fx33, Fx55, Fx65 and Dxyn then step through their
// bytes, registers or drawn rows. A two-word queue takes input while the sequencer works
// or waits on a full result register. Reset needs no clearing pass.
module chip8_instruction_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] instruction_i,
  input  logic [15:0] key_mask_i,
  input  logic [7:0]  random_byte_i,
  input  logic [11:0] load_address_i,
  input  logic [7:0]  load_data_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] next_pc_o,
  output logic [15:0] index_value_o,
  output logic [3:0]  dest_register_o,
  output logic [7:0]  dest_value_o,
  output logic [7:0]  flag_value_o,
  output logic        collision_o,
  output logic        screen_changed_o,
  output logic        waiting_for_key_o,
  output logic        sound_on_o,
  output logic [7:0]  delay_value_o
);

  `include "chip8_instruction_execute_core_assert.svh"

  chip8_pkg::item_t  item;
  chip8_pkg::qstat_t qstat;
  chip8_pkg::estat_t estat;
  logic              item_valid, item_take;

  chip8_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .opcode_i       (opcode_i),
    .instruction_i  (instruction_i),
    .key_mask_i     (key_mask_i),
    .random_byte_i  (random_byte_i),
    .load_address_i (load_address_i),
    .load_data_i    (load_data_i),
    .item_o         (item),
    .valid_o        (item_valid),
    .take_i         (item_take),
    .stat_o         (qstat)
  );

  chip8_exec u_exec (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .item_i            (item),
    .valid_i           (item_valid),
    .take_o            (item_take),
    .pop               (pop),
    .empty             (empty),
    .next_pc_o         (next_pc_o),
    .index_value_o     (index_value_o),
    .dest_register_o   (dest_register_o),
    .dest_value_o      (dest_value_o),
    .flag_value_o      (flag_value_o),
    .collision_o       (collision_o),
    .screen_changed_o  (screen_changed_o),
    .waiting_for_key_o (waiting_for_key_o),
    .sound_on_o        (sound_on_o),
    .delay_value_o     (delay_value_o),
    .stat_o            (estat)
  );

  // The sequencer only takes a word that the queue holds.
  `CHIP8_ASSERT_IMP(a_take_needs_word, estat.take, qstat.count != '0)
  // A refused push with no take leaves the queue fill unchanged.
  `CHIP8_ASSERT_NXT(a_full_holds, push && full && !estat.take, $stable(qstat.count))
  // A new result never overwrites one that is still waiting.
  `CHIP8_ASSERT_IMP(a_no_overwrite, !empty && !pop, !estat.result_load)
  // A loaded result is visible in the next cycle.
  `CHIP8_ASSERT_NXT(a_result_shows, estat.result_load, !empty)

endmodule

// ===== bench/chip8_execute_checker.sv =====
`timescale 1ns / 100ps
// Checker for the CHIP-8 execute core: predicts every result word and compares it.
module chip8_execute_checker
  import chip8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] instruction_i,
  input  logic [15:0] key_mask_i,
  input  logic [7:0]  random_byte_i,
  input  logic [11:0] load_address_i,
  input  logic [7:0]  load_data_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [11:0] next_pc_i,
  input  logic [15:0] index_value_i,
  input  logic [3:0]  dest_register_i,
  input  logic [7:0]  dest_value_i,
  input  logic [7:0]  flag_value_i,
  input  logic        collision_i,
  input  logic        screen_changed_i,
  input  logic        waiting_for_key_i,
  input  logic        sound_on_i,
  input  logic [7:0]  delay_value_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [11:0] pc;
    logic [15:0] index;
    logic [3:0]  dreg;
    logic [7:0]  dval;
    logic [7:0]  vf;
    logic        coll;
    logic        changed;
    logic        key_wait;
    logic        sound;
    logic [7:0]  delay;
  } outcome_t;

  outcome_t    expected_q[$];
  logic [11:0] font_addr;
  logic [7:0]  vreg [16];
  logic [15:0] index_reg;
  logic [11:0] pc;
  logic [11:0] call_stack [STACK_DEPTH];
  logic [3:0]  stack_top;
  logic [7:0]  memory [MEM_BYTES];
  logic [63:0] frame [SCREEN_HEIGHT];
  logic [7:0]  delay_cnt;
  logic [7:0]  sound_cnt;

  assign pending_o = expected_q.size();

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    fail_count_o++;
  endtask

  // Applies one accepted word to the shadow machine and returns the status it leaves.
  task automatic execute_word(input logic [1:0] kind, input logic [15:0] ins,
                              input logic [15:0] keys, input logic [7:0] rnd,
                              input logic [11:0] laddr, input logic [7:0] ldata,
                              output outcome_t o);
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy, res, bits;
    logic [11:0] nnn;
    logic        wrote, skip, ok, held, found;
    logic [3:0]  dreg;
    int          xp, yp, px, py, k;
    o = '0;
    wrote = 0;
    dreg = '0;
    skip = 0;
    if (kind == KIND_LOAD) begin
      memory[laddr] = ldata;
    end else if (kind == KIND_TICK) begin
      if (delay_cnt != 0) delay_cnt--;
      if (sound_cnt != 0) sound_cnt--;
    end else if (kind == KIND_EXEC) begin
      x = ins[11:8];
      y = ins[7:4];
      n = ins[3:0];
      kk = ins[7:0];
      nnn = ins[11:0];
      vx = vreg[x];
      vy = vreg[y];
      pc = pc + 12'd2;
      case (ins[15:12])
        4'h0: begin
          if (ins == 16'h00E0) begin
            for (int r = 0; r < SCREEN_HEIGHT; r++) begin
              if (frame[r] != 0) o.changed = 1;
              frame[r] = '0;
            end
          end else if (ins == 16'h00EE) begin
            stack_top = stack_top - 4'd1;
            pc = call_stack[stack_top];
          end
        end
        4'h1: pc = nnn;
        4'h2: begin
          call_stack[stack_top] = pc;
          stack_top = stack_top + 4'd1;
          pc = nnn;
        end
        4'h3: skip = (vx == kk);
        4'h4: skip = (vx != kk);
        4'h5: skip = (n == 0) && (vx == vy);
        4'h6: begin vreg[x] = kk; wrote = 1; dreg = x; end
        4'h7: begin vreg[x] = vx + kk; wrote = 1; dreg = x; end
        4'h8: begin
          ok = 1;
          res = '0;
          case (n)
            4'h0: res = vy;
            4'h1: res = vx | vy;
            4'h2: res = vx & vy;
            4'h3: res = vx ^ vy;
            4'h4: begin vreg[15] = ({1'b0, vx} + vy) > 255; res = vx + vy; end
            4'h5: begin vreg[15] = vx > vy; res = vx - vy; end
            4'h6: begin vreg[15] = vx[0]; res = vx >> 1; end
            4'h7: begin vreg[15] = vy > vx; res = vy - vx; end
            4'hE: begin vreg[15] = vx[7]; res = vx << 1; end
            default: ok = 0;
          endcase
          // VF is written first, so with x equal to F the result overrides the flag.
          if (ok) begin vreg[x] = res; wrote = 1; dreg = x; end
        end
        4'h9: skip = (n == 0) && (vx != vy);
        4'hA: index_reg = {4'h0, nnn};
        4'hB: pc = vreg[0] + nnn;
        4'hC: begin vreg[x] = rnd & kk; wrote = 1; dreg = x; end
        4'hD: begin
          xp = vx % SCREEN_WIDTH;
          yp = vy % SCREEN_HEIGHT;
          for (int r = 0; r < n; r++) begin
            py = yp + r;
            if (py >= SCREEN_HEIGHT) break;
            bits = memory[(int'(index_reg) + r) % MEM_BYTES];
            for (int c = 0; c < 8; c++) begin
              px = xp + c;
              if (bits[7-c] && px < SCREEN_WIDTH) begin
                if (frame[py][px]) o.coll = 1;
                frame[py][px] = ~frame[py][px];
                o.changed = 1;
              end
            end
          end
          vreg[15] = {7'd0, o.coll};
          wrote = 1;
          dreg = 4'hF;
        end
        4'hE: begin
          held = (vx < 16) && keys[vx[3:0]];
          if (kk == 8'h9E) skip = held;
          else if (kk == 8'hA1) skip = !held;
        end
        default: begin
          case (kk)
            8'h07: begin vreg[x] = delay_cnt; wrote = 1; dreg = x; end
            8'h0A: begin
              found = 0;
              for (k = 0; k < 16; k++) if (keys[k]) begin found = 1; break; end
              if (found) begin vreg[x] = k[7:0]; wrote = 1; dreg = x; end
              else begin pc = pc - 12'd2; o.key_wait = 1; end
            end
            8'h15: delay_cnt = vx;
            8'h18: sound_cnt = vx;
            8'h1E: index_reg = index_reg + vx;
            8'h29: index_reg = font_addr + 16'd5 * vx;
            8'h33: begin
              memory[(int'(index_reg) + 0) % MEM_BYTES] = vx / 100;
              memory[(int'(index_reg) + 1) % MEM_BYTES] = (vx / 10) % 10;
              memory[(int'(index_reg) + 2) % MEM_BYTES] = vx % 10;
            end
            8'h55: for (int i = 0; i <= x; i++)
              memory[(int'(index_reg) + i) % MEM_BYTES] = vreg[i];
            8'h65: begin
              for (int i = 0; i <= x; i++)
                vreg[i] = memory[(int'(index_reg) + i) % MEM_BYTES];
              wrote = 1;
              dreg = x;
            end
            default: ;
          endcase
        end
      endcase
      if (skip) pc = pc + 12'd2;
    end
    o.pc = pc;
    o.index = index_reg;
    o.dreg = wrote ? dreg : 4'd0;
    o.dval = wrote ? vreg[dreg] : 8'd0;
    o.vf = vreg[15];
    o.sound = (sound_cnt != 0);
    o.delay = delay_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want, got;
    if (!rst_ni) begin
      expected_q.delete();
      font_addr = FONT_RESET;
      foreach (vreg[i]) vreg[i] = '0;
      index_reg = '0;
      pc = PC_RESET;
      foreach (call_stack[i]) call_stack[i] = '0;
      stack_top = '0;
      foreach (memory[i]) memory[i] = '0;
      foreach (frame[i]) frame[i] = '0;
      delay_cnt = '0;
      sound_cnt = '0;
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (pop && !empty) begin
        got = '{next_pc_i, index_value_i, dest_register_i, dest_value_i, flag_value_i,
                collision_i, screen_changed_i, waiting_for_key_i, sound_on_i,
                delay_value_i};
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected", $realtime);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (got.pc != want.pc) report_mismatch("next_pc", got.pc, want.pc);
          if (got.index != want.index) report_mismatch("index_value", got.index, want.index);
          if (got.dreg != want.dreg) report_mismatch("dest_register", got.dreg, want.dreg);
          if (got.dval != want.dval) report_mismatch("dest_value", got.dval, want.dval);
          if (got.vf != want.vf) report_mismatch("flag_value", got.vf, want.vf);
          if (got.coll != want.coll) report_mismatch("collision", got.coll, want.coll);
          if (got.changed != want.changed)
            report_mismatch("screen_changed", got.changed, want.changed);
          if (got.key_wait != want.key_wait)
            report_mismatch("waiting_for_key", got.key_wait, want.key_wait);
          if (got.sound != want.sound) report_mismatch("sound_on", got.sound, want.sound);
          if (got.delay != want.delay) report_mismatch("delay_value", got.delay, want.delay);
        end
      end
      if (push && !full) begin
        execute_word(opcode_i, instruction_i, key_mask_i, random_byte_i, load_address_i,
                     load_data_i, want);
        expected_q.push_back(want);
      end
      if (cfg_we_i) font_addr = cfg_wdata_i;
    end
  end

endmodule

// ===== bench/tb_chip8_instruction_execute_core.sv =====
`timescale 1ns / 100ps
// Testbench top for the CHIP-8 execute core: clock, reset, stimulus and verdict.
module tb_chip8_instruction_execute_core;
  import chip8_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [11:0] cfg_wdata_i = '0;
  logic        push = 0;
  logic        full;
  logic [1:0]  opcode_i = KIND_EXEC;
  logic [15:0] instruction_i = '0;
  logic [15:0] key_mask_i = '0;
  logic [7:0]  random_byte_i = '0;
  logic [11:0] load_address_i = '0;
  logic [7:0]  load_data_i = '0;
  logic        empty;
  logic        pop = 0;
  logic [11:0] next_pc_o;
  logic [15:0] index_value_o;
  logic [3:0]  dest_register_o;
  logic [7:0]  dest_value_o;
  logic [7:0]  flag_value_o;
  logic        collision_o, screen_changed_o, waiting_for_key_o, sound_on_o;
  logic [7:0]  delay_value_o;
  int          fail_count, pending, checked;

  bit          no_idle;
  int          tx_burst, rx_burst, popped;
  int          n_exec, n_load, n_tick;
  logic [3:0]  call_depth;
  bit [15:0]   slot_filled;

  always #5 clk_i = ~clk_i;

  chip8_instruction_execute_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .push(push), .full(full), .opcode_i(opcode_i), .instruction_i(instruction_i),
    .key_mask_i(key_mask_i), .random_byte_i(random_byte_i),
    .load_address_i(load_address_i), .load_data_i(load_data_i),
    .empty(empty), .pop(pop), .next_pc_o(next_pc_o), .index_value_o(index_value_o),
    .dest_register_o(dest_register_o), .dest_value_o(dest_value_o),
    .flag_value_o(flag_value_o), .collision_o(collision_o),
    .screen_changed_o(screen_changed_o), .waiting_for_key_o(waiting_for_key_o),
    .sound_on_o(sound_on_o), .delay_value_o(delay_value_o)
  );

  chip8_execute_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .push(push), .full(full), .opcode_i(opcode_i), .instruction_i(instruction_i),
    .key_mask_i(key_mask_i), .random_byte_i(random_byte_i),
    .load_address_i(load_address_i), .load_data_i(load_data_i),
    .empty(empty), .pop(pop), .next_pc_i(next_pc_o), .index_value_i(index_value_o),
    .dest_register_i(dest_register_o), .dest_value_i(dest_value_o),
    .flag_value_i(flag_value_o), .collision_i(collision_o),
    .screen_changed_i(screen_changed_o), .waiting_for_key_i(waiting_for_key_o),
    .sound_on_i(sound_on_o), .delay_value_i(delay_value_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Idle cycles before the next word; occasional bursts run with no idling at all.
  function automatic int idle_cycles(ref int burst);
    if (no_idle) return 0;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 15);
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [15:0] ins,
                           input logic [15:0] keys, input logic [7:0] rnd,
                           input logic [11:0] laddr, input logic [7:0] ldata);
    int gap;
    gap = idle_cycles(tx_burst);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1;
    opcode_i <= kind;
    instruction_i <= ins;
    key_mask_i <= keys;
    random_byte_i <= rnd;
    load_address_i <= laddr;
    load_data_i <= ldata;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    case (kind)
      KIND_EXEC: n_exec++;
      KIND_LOAD: n_load++;
      KIND_TICK: n_tick++;
      default: ;
    endcase
  endtask

  // Sends one instruction; a return with no filled slot under it becomes a clear.
  task automatic send_instruction(input logic [15:0] ins, input logic [15:0] keys);
    if (ins == 16'h00EE && !slot_filled[call_depth - 4'd1]) ins = 16'h00E0;
    if (ins[15:12] == 4'h2) begin
      slot_filled[call_depth] = 1;
      call_depth++;
    end else if (ins == 16'h00EE) begin
      call_depth--;
    end
    send_word(KIND_EXEC, ins, keys, $urandom, $urandom, $urandom);
  endtask

  function automatic logic [15:0] random_instruction();
    logic [15:0] ins;
    logic [7:0]  fsub [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
    ins = $urandom;
    case (ins[15:12])
      4'h0: case ($urandom_range(0, 3))
              0: ins = 16'h00E0;
              1, 2: ins = 16'h00EE;
              default: ;
            endcase
      4'h5, 4'h9: if ($urandom_range(0, 3) != 0) ins[3:0] = 4'h0;
      4'h6: if ($urandom_range(0, 1)) ins[7:0] = $urandom_range(0, 17);
      4'h8: if ($urandom_range(0, 5) == 0) ins[3:0] = 4'hE;
            else if ($urandom_range(0, 5) != 0) ins[3:0] = $urandom_range(0, 7);
      4'hE: if ($urandom_range(0, 5) != 0) ins[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
      4'hF: if ($urandom_range(0, 7) != 0) ins[7:0] = fsub[$urandom_range(0, 8)];
      default: ;
    endcase
    return ins;
  endfunction

  task automatic random_phase(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        send_word(KIND_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 16)
        send_word(KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 18)
        send_word(KIND_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send_instruction(random_instruction(),
                         ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
    end
  endtask

  // Waits for every result, then writes the font base while the core is idle.
  task automatic drain_and_set_font(input logic [11:0] base);
    push <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Receiver: random stalls, plus one long hold-off that lets the core back up.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = idle_cycles(rx_burst);
      if (popped == 300) gap = 200;
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      popped++;
    end
  end

  initial begin
    logic [15:0] directed [$] = '{
      16'h00E0, 16'h6AFF, 16'h6B01, 16'h8AB4, 16'h6FC8, 16'h8FA4, 16'h8AB5, 16'h8AB7,
      16'h8A06, 16'h8A0E, 16'h8AB8, 16'h3A00, 16'h4A00, 16'h5AB0, 16'h9AB0, 16'hAFFE,
      16'h6C3F, 16'h6D1F, 16'hDCDF, 16'hDCDF, 16'hECA1, 16'hF00A, 16'hFC33, 16'hFF55,
      16'hFF65, 16'hF029, 16'hFA1E, 16'h2ABC, 16'h00EE, 16'hBFFF, 16'hFC15, 16'hFC18};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    drain_and_set_font(12'hFFF);
    // Fill all of memory so that no read ever hits a byte that was never written.
    no_idle = 1;
    for (int a = 0; a < MEM_BYTES; a++)
      send_word(KIND_LOAD, '0, '0, '0, 12'(a), $urandom);
    no_idle = 0;
    foreach (directed[i]) send_instruction(directed[i], 16'h0000);
    send_word(KIND_TICK, '0, '0, '0, '0, '0);
    send_word(KIND_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 12'hFFF, 8'hFF);
    drain_and_set_font(12'h000);
    random_phase(250);
    drain_and_set_font($urandom);
    random_phase(250);
    drain_and_set_font(FONT_RESET);
    random_phase(200);
    push <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d instructions, %0d loads and %0d ticks under four font bases.",
             n_exec, n_load, n_tick);
    $display("Compared %0d result words with random stalls on both sides.", checked);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/chip8_pkg.sv
design/chip8_front.sv
design/chip8_exec.sv
design/chip8_instruction_execute_core.sv
bench/chip8_execute_checker.sv
bench/tb_chip8_instruction_execute_core.sv
